// ----- rtl/core/excavator_spin_and_actuator_control_assert.svh -----
// Assertion helpers shared by the excavator control RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef EXCAVATOR_SPIN_AND_ACTUATOR_CONTROL_ASSERT_SVH
`define EXCAVATOR_SPIN_AND_ACTUATOR_CONTROL_ASSERT_SVH

// The condition holds on every clock edge.
`define ESAC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ESAC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ESAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/esac_pkg.sv -----
`timescale 1ns / 1ps
package esac_pkg;

  // Potentiometer code width as it arrives on the stream.
  localparam int PosW = 12;

  localparam int InDataW  = 48;
  localparam int OutDataW = 56;

  // Command codes carried in the input tuser.
  typedef enum logic [2:0] {
    ReqTick      = 3'd0,
    ReqSpin      = 3'd1,
    ReqStopSpin  = 3'd2,
    ReqActuate   = 3'd3,
    ReqStopAct   = 3'd4,
    ReqLock      = 3'd5,
    ReqReset     = 3'd6
  } req_t;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    RegSteadyGain = 3'd0,
    RegPlungeGain = 3'd1,
    RegSlowZone   = 3'd2,
    RegRetractLim = 3'd3,
    RegDeployLim  = 3'd4,
    RegFastDuty   = 3'd5,
    RegSlowDuty   = 3'd6,
    RegPotOffset  = 3'd7
  } cfg_reg_t;

  // Actuator motion state.
  typedef enum logic [2:0] {
    ModeIdle    = 3'b001,
    ModeRetract = 3'b010,
    ModeDeploy  = 3'b100
  } act_mode_t;

  // Reported actuator mode codes.
  localparam logic [1:0] ActCodeIdle    = 2'd0;
  localparam logic [1:0] ActCodeRetract = 2'd1;
  localparam logic [1:0] ActCodeDeploy  = 2'd2;

  // Register reset values.
  localparam logic [15:0] SteadyGainRst = 16'd16384;
  localparam logic [15:0] PlungeGainRst = 16'd32767;
  localparam logic [11:0] SlowZoneRst   = 12'd2048;
  localparam logic [11:0] RetractLimRst = 12'd256;
  localparam logic [11:0] DeployLimRst  = 12'd3840;
  localparam logic [14:0] FastDutyRst   = 15'd32767;
  localparam logic [14:0] SlowDutyRst   = 15'd8192;
  localparam logic [11:0] PotOffsetRst  = 12'd0;

  localparam logic signed [17:0] Sat16Max = 18'sh07FFF;
  localparam logic signed [17:0] Sat16Min = -18'sh08000;

  // Clamp an 18-bit signed value into the signed 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > Sat16Max) begin
      r = 16'sh7FFF;
    end else if (v < Sat16Min) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] mode_code(input act_mode_t m);
    logic [1:0] c;
    case (m)
      ModeRetract: begin
        c = ActCodeRetract;
      end
      ModeDeploy: begin
        c = ActCodeDeploy;
      end
      default: begin
        c = ActCodeIdle;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/excavator_spin_and_actuator_control.sv -----
`timescale 1ns / 1ps
// A request is first captured in the input register; its result is then written to the
// result register, and out_tvalid rises once that register holds it.
// Throughput: one request per cycle while out_tready is high; input and result registers
// let the block take a new request while the previous result still waits for out_tready.
// Reset (rst_n low, synchronous): all motion state clears, the actuator goes idle and the
// configuration registers return to their documented defaults.
module excavator_spin_and_actuator_control #(
  parameter int RAMP_STEP    = 1638,
  parameter int LIMIT_MARGIN = 41,
  parameter int POS_BITS     = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [11:0] left_pos, [23:12] right_pos, [39:24] spin_target, [40] spin_invert,
  // [41] ramp_due, [42] retract_request, [43] lock_request, [47:44] zero
  input  logic [esac_pkg::InDataW-1:0]    in_tdata,
  // [2:0] req_type
  input  logic [2:0]                      in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] spin_drive, [16] spin_active, [32:17] ramped_speed, [34:33] act_mode,
  // [35] act_pwm_on, [36] act_dir_pin, [51:37] act_drive, [52] lock_held, [55:53] zero
  output logic [esac_pkg::OutDataW-1:0]   out_tdata,
  // Configuration port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [4:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  import esac_pkg::*;

  // Positions are masked down to POS_BITS bits before any compare.
  localparam logic [PosW-1:0] PosMask = (POS_BITS >= PosW) ? {PosW{1'b1}} :
                                        PosW'((1 << POS_BITS) - 1);
  localparam logic signed [13:0] LimitMargin = 14'(LIMIT_MARGIN);
  localparam logic signed [17:0] RampStep    = 18'(RAMP_STEP);

  // ------------------------------------------------------------------
  // Configuration registers. Writes are only to be issued while the block is
  // idle (the block does not enforce this), so the datapath may read them directly.
  // ------------------------------------------------------------------
  logic signed [15:0] steady_gain_r, plunge_gain_r;
  logic [11:0]        slow_zone_r, retract_lim_r, deploy_lim_r;
  logic [14:0]        fast_duty_r, slow_duty_r;
  logic signed [11:0] pot_offset_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_gain_r <= SteadyGainRst;
      plunge_gain_r <= PlungeGainRst;
      slow_zone_r   <= SlowZoneRst;
      retract_lim_r <= RetractLimRst;
      deploy_lim_r  <= DeployLimRst;
      fast_duty_r   <= FastDutyRst;
      slow_duty_r   <= SlowDutyRst;
      pot_offset_r  <= PotOffsetRst;
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegSteadyGain: begin
          steady_gain_r <= cfg_pwdata[15:0];
        end
        RegPlungeGain: begin
          plunge_gain_r <= cfg_pwdata[15:0];
        end
        RegSlowZone: begin
          slow_zone_r <= cfg_pwdata[11:0];
        end
        RegRetractLim: begin
          retract_lim_r <= cfg_pwdata[11:0];
        end
        RegDeployLim: begin
          deploy_lim_r <= cfg_pwdata[11:0];
        end
        RegFastDuty: begin
          fast_duty_r <= cfg_pwdata[14:0];
        end
        RegSlowDuty: begin
          slow_duty_r <= cfg_pwdata[14:0];
        end
        RegPotOffset: begin
          pot_offset_r <= cfg_pwdata[11:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Reads return the raw register bits, zero extended.
  always_comb begin
    case (cfg_sel)
      RegSteadyGain: cfg_prdata = {16'd0, steady_gain_r};
      RegPlungeGain: cfg_prdata = {16'd0, plunge_gain_r};
      RegSlowZone:   cfg_prdata = {20'd0, slow_zone_r};
      RegRetractLim: cfg_prdata = {20'd0, retract_lim_r};
      RegDeployLim:  cfg_prdata = {20'd0, deploy_lim_r};
      RegFastDuty:   cfg_prdata = {17'd0, fast_duty_r};
      RegSlowDuty:   cfg_prdata = {17'd0, slow_duty_r};
      RegPotOffset:  cfg_prdata = {20'd0, pot_offset_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshake. The input register holds one request; it moves into the
  // datapath whenever the result register is empty or being drained.
  // ------------------------------------------------------------------
  logic                  in_valid_r;
  logic [InDataW-1:0]    in_data_r;
  logic [2:0]            in_req_r;
  logic                  out_valid_r;
  logic [OutDataW-1:0]   out_data_r;
  logic                  advance;
  logic                  process;

  assign advance    = !out_valid_r || out_tready;
  assign process    = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_req_r  <= in_tuser;
    end
  end

  // ------------------------------------------------------------------
  // Controller state.
  // ------------------------------------------------------------------
  logic signed [15:0] speed_r, speed_nxt;
  logic signed [15:0] drive_r, drive_nxt;
  logic               spinning_r, spinning_nxt;
  logic               locked_r, locked_nxt;
  act_mode_t          mode_r, mode_nxt;
  logic [14:0]        duty_r, duty_nxt;
  logic               dir_r, dir_nxt;
  logic               pwm_r, pwm_nxt;

  // Request fields.
  logic [11:0]        f_left, f_right;
  logic signed [15:0] f_target;
  logic               f_invert, f_ramp_due, f_retract, f_lock;
  req_t               f_req;

  assign f_left     = in_data_r[11:0] & PosMask;
  assign f_right    = in_data_r[23:12] & PosMask;
  assign f_target   = in_data_r[39:24];
  assign f_invert   = in_data_r[40];
  assign f_ramp_due = in_data_r[41];
  assign f_retract  = in_data_r[42];
  assign f_lock     = in_data_r[43];
  assign f_req      = req_t'(in_req_r);

  // Positions: the right pot is offset-corrected, then upper and lower
  // are the max and min of the two sides. 14 bits signed hold every case.
  logic signed [13:0] left_s, right_s, upper, lower;
  logic signed [13:0] rlim, dlim, szone;
  logic               at_retract_lim, at_deploy_lim, in_slow_zone;
  logic               tick_retract_stop, tick_deploy_stop;

  assign left_s  = $signed({2'b00, f_left});
  assign right_s = $signed({2'b00, f_right}) - $signed({{2{pot_offset_r[11]}}, pot_offset_r});
  assign upper   = (left_s > right_s) ? left_s : right_s;
  assign lower   = (left_s < right_s) ? left_s : right_s;
  assign rlim    = $signed({2'b00, retract_lim_r & PosMask});
  assign dlim    = $signed({2'b00, deploy_lim_r & PosMask});
  assign szone   = $signed({2'b00, slow_zone_r & PosMask});

  assign at_retract_lim    = lower <= rlim;
  assign at_deploy_lim     = upper >= dlim;
  assign in_slow_zone      = lower >= szone;
  // Ticks only stop the actuator once a limit is overrun by the margin.
  assign tick_retract_stop = lower <= (rlim - LimitMargin);
  assign tick_deploy_stop  = upper >= (dlim + LimitMargin);

  // Spin path: target (optionally negated), ramp toward it, then scale.
  logic signed [15:0] target_adj;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic signed [17:0] speed_up, speed_dn;
  logic signed [15:0] speed_ramped;
  logic signed [15:0] gain;
  logic signed [31:0] prod;
  logic signed [32:0] prod_rnd;
  logic signed [15:0] pwr;
  logic [16:0]        cur_mag;
  logic               drive_grows;

  always_comb begin
    if (f_invert) begin
      target_adj = (f_target == 16'sh8000) ? 16'sh7FFF : -f_target;
    end else begin
      target_adj = f_target;
    end
  end

  assign diff     = $signed({target_adj[15], target_adj}) - $signed({speed_r[15], speed_r});
  assign mag      = diff[16] ? 17'(-diff) : 17'(diff);
  assign speed_up = $signed({{2{speed_r[15]}}, speed_r}) + RampStep;
  assign speed_dn = $signed({{2{speed_r[15]}}, speed_r}) - RampStep;

  always_comb begin
    if (!f_ramp_due) begin
      speed_ramped = speed_r;
    end else if ($signed({1'b0, mag}) * 2 < RampStep) begin
      // Close enough: snap straight to the target.
      speed_ramped = target_adj;
    end else if (!diff[16]) begin
      speed_ramped = sat16(speed_up);
    end else begin
      speed_ramped = sat16(speed_dn);
    end
  end

  // Steady gain once fully deployed, plunge gain otherwise. The product
  // is rounded half up to Q1.15 and saturated.
  assign gain     = at_deploy_lim ? steady_gain_r : plunge_gain_r;
  assign prod     = speed_ramped * gain;
  assign prod_rnd = $signed({prod[31], prod}) + 33'sd16384;
  assign pwr      = sat16(prod_rnd[32:15]);

  // A held lock only lets the drive magnitude grow.
  assign cur_mag     = drive_r[15] ? 17'(-$signed({drive_r[15], drive_r})) : {1'b0, drive_r};
  assign drive_grows = $signed({1'b0, cur_mag}) < $signed({{2{pwr[15]}}, pwr});

  // Next-state selection by command.
  always_comb begin
    speed_nxt    = speed_r;
    drive_nxt    = drive_r;
    spinning_nxt = spinning_r;
    locked_nxt   = locked_r;
    mode_nxt     = mode_r;
    duty_nxt     = duty_r;
    dir_nxt      = dir_r;
    pwm_nxt      = pwm_r;
    case (f_req)
      ReqTick: begin
        if (mode_r == ModeRetract) begin
          if (tick_retract_stop) begin
            mode_nxt = ModeIdle;
            duty_nxt = '0;
            dir_nxt  = 1'b0;
            pwm_nxt  = 1'b0;
          end else begin
            duty_nxt = fast_duty_r;
          end
        end else if (mode_r == ModeDeploy) begin
          if (tick_deploy_stop) begin
            mode_nxt = ModeIdle;
            duty_nxt = '0;
            dir_nxt  = 1'b0;
            pwm_nxt  = 1'b0;
          end else begin
            duty_nxt = in_slow_zone ? slow_duty_r : fast_duty_r;
          end
        end
      end
      ReqSpin: begin
        speed_nxt = speed_ramped;
        if (!locked_r || drive_grows) begin
          spinning_nxt = 1'b1;
          drive_nxt    = pwr;
        end
      end
      ReqStopSpin: begin
        if (spinning_r && !locked_r) begin
          spinning_nxt = 1'b0;
          speed_nxt    = '0;
          drive_nxt    = '0;
        end
      end
      ReqActuate: begin
        if (f_retract) begin
          if (at_retract_lim) begin
            mode_nxt = ModeIdle;
            duty_nxt = '0;
            dir_nxt  = 1'b0;
            pwm_nxt  = 1'b0;
          end else if (mode_r != ModeRetract) begin
            mode_nxt = ModeRetract;
            dir_nxt  = 1'b1;
            pwm_nxt  = 1'b1;
            duty_nxt = fast_duty_r;
          end
        end else begin
          if (at_deploy_lim) begin
            mode_nxt = ModeIdle;
            duty_nxt = '0;
            dir_nxt  = 1'b0;
            pwm_nxt  = 1'b0;
          end else if (mode_r != ModeDeploy) begin
            mode_nxt = ModeDeploy;
            dir_nxt  = 1'b0;
            pwm_nxt  = 1'b1;
            duty_nxt = in_slow_zone ? slow_duty_r : fast_duty_r;
          end
        end
      end
      ReqStopAct: begin
        mode_nxt = ModeIdle;
        duty_nxt = '0;
        dir_nxt  = 1'b0;
        pwm_nxt  = 1'b0;
      end
      ReqLock: begin
        locked_nxt = f_lock;
      end
      ReqReset: begin
        speed_nxt    = '0;
        drive_nxt    = '0;
        spinning_nxt = 1'b0;
        locked_nxt   = 1'b0;
        mode_nxt     = ModeIdle;
        duty_nxt     = '0;
        dir_nxt      = 1'b0;
        pwm_nxt      = 1'b0;
      end
      default: begin
        // Unknown command: state is reported unchanged.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= '0;
      drive_r    <= '0;
      spinning_r <= 1'b0;
      locked_r   <= 1'b0;
      mode_r     <= ModeIdle;
      duty_r     <= '0;
      dir_r      <= 1'b0;
      pwm_r      <= 1'b0;
    end else if (process) begin
      speed_r    <= speed_nxt;
      drive_r    <= drive_nxt;
      spinning_r <= spinning_nxt;
      locked_r   <= locked_nxt;
      mode_r     <= mode_nxt;
      duty_r     <= duty_nxt;
      dir_r      <= dir_nxt;
      pwm_r      <= pwm_nxt;
    end
  end

  // Result register: the state after the command, packed for the stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data_r <= {3'd0, locked_nxt, duty_nxt, dir_nxt, pwm_nxt, mode_code(mode_nxt),
                     speed_nxt, spinning_nxt, drive_nxt};
    end
  end

  `include "excavator_spin_and_actuator_control_assert.svh"

  `ESAC_ASSERT_IMPLY(a_idle_quiet, mode_r == ModeIdle, !pwm_r && !dir_r && duty_r == '0,
                     "idle actuator is still driven")
  `ESAC_ASSERT_IMPLY(a_moving_pwm, mode_r != ModeIdle,
                     pwm_r && (dir_r == (mode_r == ModeRetract)),
                     "moving actuator has wrong pwm or direction")
  `ESAC_ASSERT_ALWAYS(a_drive_needs_spin, spinning_r || drive_r == '0,
                      "spin drive nonzero while stopped")
  `ESAC_ASSERT_NEXT(a_hold_stalled, in_valid_r && !advance, in_valid_r,
                    "stalled request dropped from input register")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import esac_pkg::*;

  // These match the parameters that the block is built with below.
  localparam int RampStep    = 1638;
  localparam int LimitMargin = 41;

  // Command code 7 has no meaning to the block. It must leave every state bit alone.
  localparam logic [2:0] ReqUnknown = 3'd7;

  // Flag bits of a command, in the order {lock, retract, ramp_due, invert}.
  localparam logic [3:0] FlagNone    = 4'b0000;
  localparam logic [3:0] FlagInvert  = 4'b0001;
  localparam logic [3:0] FlagRamp    = 4'b0010;
  localparam logic [3:0] FlagRetract = 4'b0100;
  localparam logic [3:0] FlagLock    = 4'b1000;

  // The run is cut off here. A correct run needs only a small fraction of this.
  localparam int CycleLimit = 200000;

  // The register sets that the run loads between phases.
  typedef enum int {SetMax, SetMin, SetRandom, SetDefault} setting_t;

  // One command request, packed as in the lower 44 bits of in_tdata. The last member is at bit 0.
  typedef struct packed {
    logic               lock_request;
    logic               retract_request;
    logic               ramp_due;
    logic               spin_invert;
    logic signed [15:0] spin_target;
    logic [11:0]        right_pos;
    logic [11:0]        left_pos;
  } command_t;

  // One status result, packed as in the lower 53 bits of out_tdata.
  typedef struct packed {
    logic               lock_held;
    logic [14:0]        act_drive;
    logic               act_dir_pin;
    logic               act_pwm_on;
    logic [1:0]         act_mode;
    logic signed [15:0] ramped_speed;
    logic               spin_active;
    logic signed [15:0] spin_drive;
  } status_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata = '0;
  logic [2:0]           in_tuser = ReqTick;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [4:0]           cfg_paddr = '0;
  logic [31:0]          cfg_pwdata = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  excavator_spin_and_actuator_control #(
    .RAMP_STEP   (RampStep),
    .LIMIT_MARGIN(LimitMargin),
    .POS_BITS    (PosW)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // The clock has a period of 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // This is the testbench's own copy of the controller registers. They start at the reset values.
  int gain_steady   = 16384;
  int gain_plunge   = 32767;
  int zone_slow     = 2048;
  int limit_retract = 256;
  int limit_deploy  = 3840;
  int duty_fast     = 32767;
  int duty_slow     = 8192;
  int offset_right  = 0;

  // This is the testbench's own copy of the controller state. Reset clears all of it.
  int         ramp_speed     = 0;
  int         spin_drive_now = 0;
  logic       spin_on        = 1'b0;
  logic       lock_on        = 1'b0;
  logic [1:0] act_state      = ActCodeIdle;
  int         act_duty       = 0;
  logic       act_dir        = 1'b0;
  logic       act_pwm        = 1'b0;

  // Each accepted request adds one status that the block must return, oldest first.
  status_t expected_status[$];

  int  mismatches      = 0;
  int  results_checked = 0;
  int  requests_sent   = 0;
  int  register_writes = 0;
  int  cycle_count     = 0;
  // Idling switches and the length of the long output stall.
  logic source_gaps_on  = 1'b1;
  logic sink_stalls_on  = 1'b1;
  int   hold_off_cycles = 0;

  function automatic int clamp_q15(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return int'(v);
  endfunction

  // Stopping the actuator has an effect only while it moves.
  function automatic void stop_actuator();
    if (act_state != ActCodeIdle) begin
      act_state = ActCodeIdle;
      act_pwm   = 1'b0;
      act_dir   = 1'b0;
      act_duty  = 0;
    end
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      RegSteadyGain: gain_steady   = int'($signed(v[15:0]));
      RegPlungeGain: gain_plunge   = int'($signed(v[15:0]));
      RegSlowZone:   zone_slow     = int'(v[11:0]);
      RegRetractLim: limit_retract = int'(v[11:0]);
      RegDeployLim:  limit_deploy  = int'(v[11:0]);
      RegFastDuty:   duty_fast     = int'(v[14:0]);
      RegSlowDuty:   duty_slow     = int'(v[14:0]);
      default:       offset_right  = int'($signed(v[11:0]));
    endcase
  endfunction

  // This function applies one command to the copied state. It returns the status that follows.
  function automatic status_t advance_controller(input logic [2:0] req, input command_t c);
    int      left_code, right_code, upper, lower, target;
    longint  diff, prod, new_drive, drive_mag;
    status_t r;
    // The right pot is corrected by the offset. Neither position wraps.
    left_code  = int'(c.left_pos);
    right_code = int'(c.right_pos) - offset_right;
    upper = (left_code > right_code) ? left_code : right_code;
    lower = (left_code < right_code) ? left_code : right_code;
    case (req)
      ReqTick: begin
        // On a tick, motion stops only once the limit is passed by the margin.
        if (act_state == ActCodeRetract) begin
          if (lower <= limit_retract - LimitMargin) stop_actuator();
          else act_duty = duty_fast;
        end else if (act_state == ActCodeDeploy) begin
          if (upper >= limit_deploy + LimitMargin) stop_actuator();
          else act_duty = (lower >= zone_slow) ? duty_slow : duty_fast;
        end
      end
      ReqSpin: begin
        target = int'(c.spin_target);
        // Negating the most negative target saturates.
        if (c.spin_invert) target = clamp_q15(-longint'(target));
        if (c.ramp_due) begin
          diff = longint'(target) - ramp_speed;
          // The speed takes the target when it is nearer than half a step.
          if (2 * ((diff < 0) ? -diff : diff) < RampStep) ramp_speed = target;
          else if (diff > 0) ramp_speed = clamp_q15(ramp_speed + RampStep);
          else ramp_speed = clamp_q15(ramp_speed - RampStep);
        end
        // The steady gain applies when fully deployed, else the plunge gain. The product
        // is rounded half up.
        prod = longint'(ramp_speed) * ((upper >= limit_deploy) ? gain_steady : gain_plunge)
               + 16384;
        new_drive = clamp_q15(prod >>> 15);
        drive_mag = (spin_drive_now < 0) ? -longint'(spin_drive_now) : spin_drive_now;
        // A held lock lets the drive only grow.
        if (!lock_on || drive_mag < new_drive) begin
          spin_on        = 1'b1;
          spin_drive_now = int'(new_drive);
        end
      end
      ReqStopSpin: begin
        if (spin_on && !lock_on) begin
          spin_on        = 1'b0;
          ramp_speed     = 0;
          spin_drive_now = 0;
        end
      end
      ReqActuate: begin
        // A start at the limit stops the actuator. A start in the direction that is
        // already in progress changes nothing.
        if (c.retract_request) begin
          if (lower <= limit_retract) begin
            stop_actuator();
          end else if (act_state != ActCodeRetract) begin
            act_state = ActCodeRetract;
            act_dir   = 1'b1;
            act_pwm   = 1'b1;
            act_duty  = duty_fast;
          end
        end else begin
          if (upper >= limit_deploy) begin
            stop_actuator();
          end else if (act_state != ActCodeDeploy) begin
            act_state = ActCodeDeploy;
            act_dir   = 1'b0;
            act_pwm   = 1'b1;
            act_duty  = (lower >= zone_slow) ? duty_slow : duty_fast;
          end
        end
      end
      ReqStopAct: stop_actuator();
      ReqLock: lock_on = c.lock_request;
      ReqReset: begin
        // A reset command clears the state. The registers keep their values.
        spin_drive_now = 0;
        ramp_speed     = 0;
        stop_actuator();
        spin_on = 1'b0;
        lock_on = 1'b0;
      end
      default: begin
      end
    endcase
    r.spin_drive   = spin_drive_now[15:0];
    r.spin_active  = spin_on;
    r.ramped_speed = ramp_speed[15:0];
    r.act_mode     = act_state;
    r.act_pwm_on   = act_pwm;
    r.act_dir_pin  = act_dir;
    r.act_drive    = act_duty[14:0];
    r.lock_held    = lock_on;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, results_checked, want, got);
      end
    end
  endfunction

  function automatic void check_status(input status_t got);
    status_t want;
    if (expected_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no request waiting: %h", got);
      return;
    end
    want = expected_status.pop_front();
    compare_field("spin_drive", want.spin_drive, got.spin_drive);
    compare_field("spin_active", want.spin_active, got.spin_active);
    compare_field("ramped_speed", want.ramped_speed, got.ramped_speed);
    compare_field("act_mode", want.act_mode, got.act_mode);
    compare_field("act_pwm_on", want.act_pwm_on, got.act_pwm_on);
    compare_field("act_dir_pin", want.act_dir_pin, got.act_dir_pin);
    compare_field("act_drive", want.act_drive, got.act_drive);
    compare_field("lock_held", want.lock_held, got.lock_held);
    results_checked++;
  endfunction

  // The monitor samples all three ports at the rising edge. It checks each result that
  // is taken. It copies each register write into the registers above. It predicts the
  // status for each accepted request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_status(status_t'(out_tdata[52:0]));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        apply_register(cfg_paddr[4:2], cfg_pwdata);
        register_writes++;
      end
      if (in_tvalid && in_tready) begin
        expected_status.push_back(advance_controller(in_tuser, command_t'(in_tdata[43:0])));
      end
    end
  end

  // This is the receiver. It makes short random stalls. When the test asks for a long hold-off,
  // it keeps out_tready low and counts the cycles itself.
  always begin
    @(negedge clk);
    if (hold_off_cycles > 0) begin
      out_tready = 1'b0;
      repeat (hold_off_cycles) @(negedge clk);
      hold_off_cycles = 0;
      out_tready = 1'b1;
    end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      out_tready = 1'b1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // This watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_status.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [11:0] clamp_code(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  function automatic command_t random_command();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[43:0];
  endfunction

  // This builds a command whose two pots agree near pos, after the offset. Its other fields
  // are random.
  function automatic command_t paired_command(input int pos);
    command_t c;
    c = random_command();
    c.left_pos  = clamp_code(pos);
    c.right_pos = clamp_code(pos + offset_right + int'($urandom_range(0, 8)) - 4);
    return c;
  endfunction

  // This sends one request, sometimes after a random gap in the source.
  task automatic send_request(input logic [2:0] req, input command_t cmd);
    if (source_gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {4'b0000, cmd};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic send_fields(input logic [2:0] req, input int left, input int right,
                             input int target, input logic [3:0] flags);
    command_t c;
    c.left_pos    = 12'(left);
    c.right_pos   = 12'(right);
    c.spin_target = 16'(target);
    {c.lock_request, c.retract_request, c.ramp_due, c.spin_invert} = flags;
    send_request(req, c);
  endtask

  // This waits until every status that is due has come back, and then lets the block
  // settle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // An APB write has a setup cycle followed by an access cycle.
  task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic load_setting(input setting_t kind);
    logic [31:0] v [8];
    case (kind)
      SetMax: v = '{32'h7FFF, 32'h7FFF, 32'hFFF, 32'hFFF, 32'hFFF, 32'h7FFF, 32'h7FFF, 32'h7FF};
      SetMin: v = '{32'h8000, 32'h8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h800};
      SetRandom: begin
        // The upper bits are random too. The block must ignore them.
        foreach (v[i]) v[i] = $urandom;
      end
      default: v = '{SteadyGainRst, PlungeGainRst, SlowZoneRst, RetractLimRst,
                     DeployLimRst, FastDutyRst, SlowDutyRst, PotOffsetRst};
    endcase
    for (int i = 0; i < 8; i++) write_register(cfg_reg_t'(i), v[i]);
  endtask

  // This starts the actuator and walks both pots toward the limit with ticks.
  // Restarts, spins and stops are mixed in.
  task automatic actuate_sequence();
    logic     retract;
    int       pos, stride, ticks;
    command_t c;
    retract = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, 4095);
    else if (retract) pos = limit_retract + int'($urandom_range(0, 800));
    else pos = limit_deploy - int'($urandom_range(0, 2400));
    stride = $urandom_range(4, 120);
    ticks  = $urandom_range(4, 30);
    c = paired_command(pos);
    c.retract_request = retract;
    send_request(ReqActuate, c);
    for (int k = 0; k < ticks; k++) begin
      pos = retract ? pos - stride : pos + stride;
      c = paired_command(pos);
      case ($urandom_range(0, 15))
        0: begin
          c.retract_request = ($urandom_range(0, 2) == 0) ? !retract : retract;
          send_request(ReqActuate, c);
        end
        1: send_request(ReqSpin, c);
        2: send_request(ReqStopAct, c);
        default: send_request(ReqTick, c);
      endcase
    end
  endtask

  // This ramps the spin speed toward one target and then may stop the spin in one of several
  // ways. Lock requests are mixed in.
  task automatic spin_sequence();
    command_t    c;
    logic [15:0] goal;
    logic        flip;
    int          pos, reps;
    if ($urandom_range(0, 4) == 0) goal = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    else goal = 16'($urandom);
    flip = ($urandom_range(0, 3) == 0);
    pos  = $urandom_range(0, 4095);
    reps = $urandom_range(3, 25);
    for (int k = 0; k < reps; k++) begin
      c = paired_command(pos);
      c.spin_target = goal;
      c.spin_invert = flip;
      c.ramp_due    = ($urandom_range(0, 3) != 0);
      send_request(ReqSpin, c);
      if ($urandom_range(0, 11) == 0) send_request(ReqLock, c);
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 4095);
    end
    c = paired_command(pos);
    case ($urandom_range(0, 3))
      0: send_request(ReqStopSpin, c);
      1: begin
        c.lock_request = 1'b0;
        send_request(ReqLock, c);
        send_request(ReqStopSpin, c);
      end
      2: send_request(ReqReset, c);
      default: begin
      end
    endcase
  endtask

  // This mixes well-formed sequences with random requests until count more have been sent.
  task automatic run_mixed(input int count);
    int stop_at;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: actuate_sequence();
        5, 6, 7: spin_sequence();
        default: begin
          repeat ($urandom_range(1, 4)) send_request(3'($urandom_range(0, 7)), random_command());
        end
      endcase
    end
  endtask

  // These directed requests use the reset register values. They cover every command, the
  // edges of the ramp and the lock, and each stop at a limit.
  task automatic test_directed_commands();
    send_fields(ReqUnknown, 4095, 4095, -1, FlagInvert | FlagRamp | FlagRetract | FlagLock);
    send_fields(ReqSpin, 0, 0, 32767, FlagRamp);
    send_fields(ReqSpin, 0, 0, 32767, FlagNone);
    // The target saturates on negation. The ramp then takes one more step.
    send_fields(ReqSpin, 0, 0, -32768, FlagInvert | FlagRamp);
    // The target is within half a step, so the speed snaps to it. The steady gain applies.
    send_fields(ReqSpin, 4095, 4095, 3776, FlagRamp);
    send_fields(ReqLock, 0, 0, 0, FlagLock);
    // While locked, a smaller drive is not applied.
    send_fields(ReqSpin, 4095, 4095, 0, FlagRamp);
    send_fields(ReqStopSpin, 0, 0, 0, FlagNone);
    send_fields(ReqLock, 0, 0, 0, FlagNone);
    send_fields(ReqStopSpin, 0, 0, 0, FlagNone);
    send_fields(ReqStopSpin, 0, 0, 0, FlagNone);
    // A retract that starts at the limit does nothing.
    send_fields(ReqActuate, 200, 200, 0, FlagRetract);
    send_fields(ReqActuate, 1000, 1000, 0, FlagRetract);
    send_fields(ReqActuate, 1000, 1000, 0, FlagRetract);
    send_fields(ReqTick, 230, 240, 0, FlagNone);
    // The tick stops the actuator exactly at the retract limit less the margin.
    send_fields(ReqTick, 215, 300, 0, FlagNone);
    send_fields(ReqActuate, 1000, 1000, 0, FlagNone);
    send_fields(ReqTick, 2048, 2100, 0, FlagNone);
    send_fields(ReqActuate, 2500, 2500, 0, FlagRetract);
    send_fields(ReqStopAct, 0, 0, 0, FlagNone);
    send_fields(ReqStopAct, 0, 0, 0, FlagNone);
    send_fields(ReqActuate, 3000, 3840, 0, FlagNone);
    send_fields(ReqActuate, 3000, 3000, 0, FlagNone);
    send_fields(ReqTick, 3880, 3880, 0, FlagNone);
    send_fields(ReqTick, 3881, 3881, 0, FlagNone);
    send_fields(ReqSpin, 4095, 0, -32768, FlagRamp);
    send_fields(ReqReset, 4095, 0, 0, FlagLock);
  endtask

  // Every register is written while the block is idle. The register sets include both
  // extremes and random values. Mixed traffic runs under each set.
  task automatic test_register_extremes();
    setting_t kinds [5] = '{SetMax, SetMin, SetRandom, SetRandom, SetDefault};
    foreach (kinds[i]) begin
      drain_results();
      load_setting(kinds[i]);
      run_mixed(110);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming. The block fills
  // up and stalls its input. The sender then pauses until every result is back.
  task automatic test_backpressure();
    source_gaps_on  = 1'b0;
    hold_off_cycles = 60;
    repeat (30) send_request(3'($urandom_range(0, 7)), random_command());
    source_gaps_on = 1'b1;
    drain_results();
    run_mixed(40);
  endtask

  task automatic test_mixed_traffic();
    run_mixed(320);
  endtask

  // The last part of the run has no idling on either side.
  task automatic test_steady_stream();
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    run_mixed(150);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_commands();
    test_register_extremes();
    test_backpressure();
    test_mixed_traffic();
    test_steady_stream();

    drain_results();
    repeat (8) @(posedge clk);
    $display("summary: %0d requests sent, %0d results checked, %0d register writes,",
             requests_sent, results_checked, register_writes,
             " %0d mismatches", mismatches);
    $display("summary: spin ramp, gains and lock, actuator limits and margins, register extremes,"
             , " long output stall");
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
